FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/fecr_pkg.sv
// ----------------------------------------------------------------------------
// fecr_pkg
// Constants, types, microcode ROM and helpers of the cell rotation unit.
// ----------------------------------------------------------------------------
package fecr_pkg;

  localparam int CELL_COUNT = 64;
  localparam int CELL_BITS  = 64;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int FILL_W     = IDX_W + 1;
  localparam int DATA_W     = 64;
  localparam int OUT_IDX_W  = 6;
  localparam int PC_W       = 4;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FILL_W-1:0]    fill_t;
  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [PC_W-1:0]      pc_t;

  localparam idx_t  LAST_CELL  = IDX_W'(CELL_COUNT - 1);
  localparam cell_t CELL_ONES  = '1;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_ERASE   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_TAKE,
    OP_READ_ISSUE,
    OP_READ_CAPTURE,
    OP_NOT_INIT,
    OP_WRITE_CALC,
    OP_WRITE_STORE,
    OP_ERASE,
    OP_FORGET,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_IN_VALID,
    C_KNOWN,
    C_NOT_KNOWN,
    C_SCAN_DONE,
    C_CMD_WR,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic known;
    logic scan_done;
    logic cmd_wr;
    logic out_free;
  } stat_t;

  localparam pc_t PC_IDLE     = 4'd0;
  localparam pc_t PC_RD_CHK   = 4'd1;
  localparam pc_t PC_SC_INIT  = 4'd2;
  localparam pc_t PC_SCAN     = 4'd3;
  localparam pc_t PC_SC_TAKE  = 4'd4;
  localparam pc_t PC_RD_AFT   = 4'd5;
  localparam pc_t PC_RD_ISS   = 4'd6;
  localparam pc_t PC_RD_CAP   = 4'd7;
  localparam pc_t PC_RD_NONE  = 4'd8;
  localparam pc_t PC_WR_CHK   = 4'd9;
  localparam pc_t PC_WR_CALC  = 4'd10;
  localparam pc_t PC_WR_STORE = 4'd11;
  localparam pc_t PC_RESULT   = 4'd12;
  localparam pc_t PC_ERASE    = 4'd13;
  localparam pc_t PC_RESTART  = 4'd14;

  function automatic uword_t uw(input op_t op, input cond_t cond, input logic hold,
                                input pc_t target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.hold   = hold;
    w.target = target;
    return w;
  endfunction

  // microprogram: jump to target when cond holds, else stay (hold) or step on
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:     w = uw(OP_ACCEPT,       C_IN_VALID,  1'b1, PC_IDLE);
      PC_RD_CHK:   w = uw(OP_NOP,          C_KNOWN,     1'b0, PC_RD_ISS);
      PC_SC_INIT:  w = uw(OP_SCAN_INIT,    C_NEXT,      1'b0, PC_IDLE);
      PC_SCAN:     w = uw(OP_SCAN,         C_SCAN_DONE, 1'b1, PC_SC_TAKE);
      PC_SC_TAKE:  w = uw(OP_TAKE,         C_CMD_WR,    1'b0, PC_WR_CALC);
      PC_RD_AFT:   w = uw(OP_NOP,          C_NOT_KNOWN, 1'b0, PC_RD_NONE);
      PC_RD_ISS:   w = uw(OP_READ_ISSUE,   C_NEXT,      1'b0, PC_IDLE);
      PC_RD_CAP:   w = uw(OP_READ_CAPTURE, C_ALWAYS,    1'b0, PC_RESULT);
      PC_RD_NONE:  w = uw(OP_NOT_INIT,     C_ALWAYS,    1'b0, PC_RESULT);
      PC_WR_CHK:   w = uw(OP_NOP,          C_NOT_KNOWN, 1'b0, PC_SC_INIT);
      PC_WR_CALC:  w = uw(OP_WRITE_CALC,   C_NEXT,      1'b0, PC_IDLE);
      PC_WR_STORE: w = uw(OP_WRITE_STORE,  C_ALWAYS,    1'b0, PC_RESULT);
      PC_RESULT:   w = uw(OP_EMIT,         C_OUT_FREE,  1'b1, PC_IDLE);
      PC_ERASE:    w = uw(OP_ERASE,        C_ALWAYS,    1'b0, PC_RESULT);
      PC_RESTART:  w = uw(OP_FORGET,       C_ALWAYS,    1'b0, PC_RESULT);
      default:     w = uw(OP_NOP,          C_ALWAYS,    1'b0, PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic pc_t dispatch(input cmd_t cmd);
    pc_t pc;
    unique case (cmd)
      CMD_READ:    pc = PC_RD_CHK;
      CMD_WRITE:   pc = PC_WR_CHK;
      CMD_ERASE:   pc = PC_ERASE;
      CMD_RESTART: pc = PC_RESTART;
      default:     pc = PC_IDLE;
    endcase
    return pc;
  endfunction

  // a cell counts as used if its first or last byte is not erased
  function automatic logic cell_used(input cell_t v);
    return (v[7:0] != BYTE_ONES) || (v[CELL_BITS-1 -: 8] != BYTE_ONES);
  endfunction

endpackage

FILE: hdl/fecr_ram.sv
// ----------------------------------------------------------------------------
// fecr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fecr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fecr_useq.sv
// ----------------------------------------------------------------------------
// fecr_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module fecr_useq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [1:0]              command,
  input  fecr_pkg::stat_t         stat,
  output fecr_pkg::ctrl_t         ctrl,
  output logic                    in_ready
);

  fecr_pkg::pc_t    pc;
  fecr_pkg::pc_t    pc_next;
  fecr_pkg::uword_t word;
  logic             take;

  assign word      = fecr_pkg::ucode(pc);
  assign ctrl.op   = word.op;
  assign in_ready  = (word.op == fecr_pkg::OP_ACCEPT);

  always_comb begin
    unique case (word.cond)
      fecr_pkg::C_NEXT:      take = 1'b0;
      fecr_pkg::C_ALWAYS:    take = 1'b1;
      fecr_pkg::C_IN_VALID:  take = in_valid;
      fecr_pkg::C_KNOWN:     take = stat.known;
      fecr_pkg::C_NOT_KNOWN: take = !stat.known;
      fecr_pkg::C_SCAN_DONE: take = stat.scan_done;
      fecr_pkg::C_CMD_WR:    take = stat.cmd_wr;
      fecr_pkg::C_OUT_FREE:  take = stat.out_free;
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      if (word.cond == fecr_pkg::C_IN_VALID) begin
        pc_next = fecr_pkg::dispatch(fecr_pkg::cmd_t'(command));
      end else begin
        pc_next = word.target;
      end
    end else if (word.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + fecr_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fecr_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: hdl/fecr_datapath.sv
// ----------------------------------------------------------------------------
// fecr_datapath
// Cell pool, position and fill registers, scan pipeline and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fecr_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fecr_pkg::ctrl_t                  ctrl,
  input  logic                             in_fire,
  input  logic [1:0]                       command,
  input  logic [fecr_pkg::DATA_W-1:0]      write_data,
  output fecr_pkg::stat_t                  stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fecr_pkg::DATA_W-1:0]      read_data,
  output logic                             status,
  output logic [fecr_pkg::OUT_IDX_W-1:0]   cell_index,
  output logic                             pool_erased
);

  // control state
  logic            known;
  fecr_pkg::idx_t  active;
  fecr_pkg::fill_t fill;
  logic            scan_done;
  logic            scan_left;
  logic            scan_hit;
  logic            chk_vld;

  // payload
  fecr_pkg::cmd_t  cmd;
  fecr_pkg::cell_t wdata;
  fecr_pkg::idx_t  scan_ptr;
  fecr_pkg::idx_t  chk_ptr;
  fecr_pkg::idx_t  found;
  fecr_pkg::idx_t  wcell;
  logic            rd_blank;
  fecr_pkg::cell_t res_data;
  logic            res_status;
  fecr_pkg::idx_t  res_idx;
  logic            res_erased;

  logic            out_free;
  logic            ram_re;
  logic            ram_we;
  fecr_pkg::idx_t  ram_raddr;
  fecr_pkg::cell_t ram_rdata;
  logic            issue;
  logic            used;
  logic            wrap;
  fecr_pkg::fill_t active_ext;
  fecr_pkg::fill_t wcell_ext;

  assign out_free   = !out_valid || out_ready;
  assign issue      = (ctrl.op == fecr_pkg::OP_SCAN) && !scan_done && scan_left;
  assign ram_re     = issue || (ctrl.op == fecr_pkg::OP_READ_ISSUE);
  assign ram_raddr  = (ctrl.op == fecr_pkg::OP_READ_ISSUE) ? active : scan_ptr;
  assign ram_we     = (ctrl.op == fecr_pkg::OP_WRITE_STORE);
  assign used       = fecr_pkg::cell_used(ram_rdata);
  assign wrap       = known && (active == fecr_pkg::LAST_CELL);
  assign active_ext = {1'b0, active};
  assign wcell_ext  = {1'b0, wcell};

  assign stat.known     = known;
  assign stat.scan_done = scan_done;
  assign stat.cmd_wr    = (cmd == fecr_pkg::CMD_WRITE);
  assign stat.out_free  = out_free;

  fecr_ram #(
    .WIDTH(fecr_pkg::CELL_BITS),
    .DEPTH(fecr_pkg::CELL_COUNT)
  ) u_pool (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wcell),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      known     <= 1'b0;
      active    <= '0;
      fill      <= '0;
      scan_done <= 1'b0;
      scan_left <= 1'b0;
      scan_hit  <= 1'b0;
      chk_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((ctrl.op == fecr_pkg::OP_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        fecr_pkg::OP_SCAN_INIT: begin
          scan_done <= (fill == '0);
          scan_left <= (fill != '0);
          scan_hit  <= 1'b0;
          chk_vld   <= 1'b0;
        end
        fecr_pkg::OP_SCAN: begin
          if (!scan_done) begin
            chk_vld <= scan_left;
            if (scan_left && (scan_ptr == '0)) begin
              scan_left <= 1'b0;
            end
            if (chk_vld) begin
              if (used) begin
                scan_hit  <= 1'b1;
                scan_done <= 1'b1;
              end else if (chk_ptr == '0) begin
                scan_done <= 1'b1;
              end
            end
          end
        end
        fecr_pkg::OP_TAKE: begin
          if (scan_hit) begin
            active <= found;
            known  <= 1'b1;
          end
        end
        fecr_pkg::OP_WRITE_CALC: begin
          // pool exhausted: erase as a whole before the store
          if (wrap) begin
            fill   <= '0;
            active <= '0;
            known  <= 1'b0;
          end
        end
        fecr_pkg::OP_WRITE_STORE: begin
          active <= wcell;
          known  <= 1'b1;
          if (wcell_ext >= fill) begin
            fill <= wcell_ext + fecr_pkg::FILL_W'(1);
          end
        end
        fecr_pkg::OP_ERASE: begin
          fill   <= '0;
          active <= '0;
          known  <= 1'b0;
        end
        fecr_pkg::OP_FORGET: begin
          known <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd        <= fecr_pkg::cmd_t'(command);
      wdata      <= write_data[fecr_pkg::CELL_BITS-1:0];
      res_data   <= '0;
      res_status <= 1'b0;
      res_idx    <= '0;
      res_erased <= 1'b0;
    end
    unique case (ctrl.op)
      fecr_pkg::OP_SCAN_INIT: begin
        scan_ptr <= fecr_pkg::IDX_W'(fill - fecr_pkg::FILL_W'(1));
      end
      fecr_pkg::OP_SCAN: begin
        if (issue) begin
          chk_ptr  <= scan_ptr;
          scan_ptr <= scan_ptr - fecr_pkg::IDX_W'(1);
        end
        if (!scan_done && chk_vld && used) begin
          found <= chk_ptr;
        end
      end
      fecr_pkg::OP_READ_ISSUE: begin
        rd_blank <= (active_ext >= fill);
      end
      fecr_pkg::OP_READ_CAPTURE: begin
        res_data <= rd_blank ? fecr_pkg::CELL_ONES : ram_rdata;
        res_idx  <= active;
      end
      fecr_pkg::OP_NOT_INIT: begin
        res_status <= 1'b1;
      end
      fecr_pkg::OP_WRITE_CALC: begin
        if (wrap) begin
          wcell      <= '0;
          res_erased <= 1'b1;
        end else if (known) begin
          wcell <= active + fecr_pkg::IDX_W'(1);
        end else begin
          wcell <= '0;
        end
      end
      fecr_pkg::OP_WRITE_STORE: begin
        res_idx <= wcell;
      end
      fecr_pkg::OP_ERASE: begin
        res_erased <= 1'b1;
      end
      default: begin
      end
    endcase
    if ((ctrl.op == fecr_pkg::OP_EMIT) && out_free) begin
      read_data   <= fecr_pkg::DATA_W'(res_data);
      status      <= res_status;
      cell_index  <= fecr_pkg::OUT_IDX_W'(res_idx);
      pool_erased <= res_erased;
    end
  end

  `ASSERT_IMPLY(a_known_in_fill, known, active_ext < fill, "active cell beyond written cells")
  `ASSERT_NEXT(a_store_known, ctrl.op == fecr_pkg::OP_WRITE_STORE, known && (fill != '0), "store left position unknown")
  `ASSERT_ALWAYS(a_notinit_unknown, !($rose(out_valid) && status) || !known, "not initialized with known position")

endmodule

FILE: hdl/flash_eeprom_cell_rotation_unit.sv
// ----------------------------------------------------------------------------
// flash_eeprom_cell_rotation_unit
// EEPROM emulation over a rotating pool of flash cells, microcoded control.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result item. With the
// position unknown a scan walks down from the highest written cell, one pool
// read per cycle through the single RAM read port. A result blocked on the
// output holds the sequencer until it is taken. Erase is immediate: a fill
// count marks cells at or above it as erased, so no clearing pass is needed
// after reset or erase. The next command may be taken while a result still
// waits on the output.
module flash_eeprom_cell_rotation_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic [fecr_pkg::DATA_W-1:0]         write_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fecr_pkg::DATA_W-1:0]         read_data,
  output logic                                status,
  output logic [fecr_pkg::OUT_IDX_W-1:0]      cell_index,
  output logic                                pool_erased
);

  fecr_pkg::ctrl_t ctrl;
  fecr_pkg::stat_t stat;
  logic            in_fire;

  assign in_fire = in_valid && in_ready;

  fecr_useq u_useq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .command (command),
    .stat    (stat),
    .ctrl    (ctrl),
    .in_ready(in_ready)
  );

  fecr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .command    (command),
    .write_data (write_data),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data),
    .status     (status),
    .cell_index (cell_index),
    .pool_erased(pool_erased)
  );

endmodule

FILE: bench/flash_eeprom_cell_rotation_unit_test.sv
// ----------------------------------------------------------------------------
// flash_eeprom_cell_rotation_unit_test
// Self-checking bench for the wear-levelled EEPROM emulation unit. A local
// model of the cell pool predicts each result item; the results are checked
// field by field, in order, under several idle and stall patterns and under a
// long output hold-off.
// ----------------------------------------------------------------------------
module flash_eeprom_cell_rotation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [fecr_pkg::DATA_W-1:0]    read_data;
    logic                           status;
    logic [fecr_pkg::OUT_IDX_W-1:0] cell_index;
    logic                           pool_erased;
  } result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     command = fecr_pkg::CMD_READ;
  logic [fecr_pkg::DATA_W-1:0]    write_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [fecr_pkg::DATA_W-1:0]    read_data;
  logic                           status;
  logic [fecr_pkg::OUT_IDX_W-1:0] cell_index;
  logic                           pool_erased;

  // shadow of the flash pool
  fecr_pkg::cell_t pool_img [fecr_pkg::CELL_COUNT];
  int              cur_cell;
  bit              pos_known;

  result_t expected_q [$];
  int      errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_req;
  int      hold_left;
  int      idle_cycles;
  int      n_read, n_write, n_erase, n_restart, n_wrap, n_uninit, n_results;

  flash_eeprom_cell_rotation_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .status      (status),
    .cell_index  (cell_index),
    .pool_erased (pool_erased)
  );

  always #5 clk = ~clk;

  function automatic bit holds_image(input fecr_pkg::cell_t v);
    return (v[7:0] != fecr_pkg::BYTE_ONES) ||
           (v[fecr_pkg::CELL_BITS-1 -: 8] != fecr_pkg::BYTE_ONES);
  endfunction

  function automatic void wipe_pool();
    for (int i = 0; i < fecr_pkg::CELL_COUNT; i++) pool_img[i] = fecr_pkg::CELL_ONES;
    cur_cell  = 0;
    pos_known = 1'b0;
  endfunction

  function automatic bit locate_newest();
    for (int i = fecr_pkg::CELL_COUNT - 1; i >= 0; i--) begin
      if (holds_image(pool_img[i])) begin
        cur_cell  = i;
        pos_known = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t predict_result(input fecr_pkg::cmd_t c,
                                             input logic [fecr_pkg::DATA_W-1:0] d);
    result_t r;
    int      nxt;
    r = '0;
    case (c)
      fecr_pkg::CMD_READ: begin
        n_read++;
        if (pos_known || locate_newest()) begin
          r.read_data  = fecr_pkg::DATA_W'(pool_img[cur_cell]);
          r.cell_index = fecr_pkg::OUT_IDX_W'(cur_cell);
        end else begin
          r.status = 1'b1;
          n_uninit++;
        end
      end
      fecr_pkg::CMD_WRITE: begin
        n_write++;
        if (pos_known || locate_newest()) nxt = cur_cell + 1;
        else nxt = 0;
        if (nxt >= fecr_pkg::CELL_COUNT) begin
          wipe_pool();
          r.pool_erased = 1'b1;
          nxt = 0;
          n_wrap++;
        end
        pool_img[nxt] = d[fecr_pkg::CELL_BITS-1:0];
        cur_cell      = nxt;
        pos_known     = 1'b1;
        r.cell_index  = fecr_pkg::OUT_IDX_W'(nxt);
      end
      fecr_pkg::CMD_ERASE: begin
        n_erase++;
        wipe_pool();
        r.pool_erased = 1'b1;
      end
      default: begin
        n_restart++;
        pos_known = 1'b0;
      end
    endcase
    return r;
  endfunction

  // one item: optional idle gap, then hold valid until taken
  task automatic send_item(input fecr_pkg::cmd_t c, input logic [fecr_pkg::DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    write_data <= d;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_result(c, d));
  endtask

  // output side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result item with nothing outstanding");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, got %h", exp_r.read_data, read_data);
          errors++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          errors++;
        end
        if (cell_index !== exp_r.cell_index) begin
          $error("cell_index: expected %0d, got %0d", exp_r.cell_index, cell_index);
          errors++;
        end
        if (pool_erased !== exp_r.pool_erased) begin
          $error("pool_erased: expected %0d, got %0d", exp_r.pool_erased, pool_erased);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [fecr_pkg::DATA_W-1:0] random_image();
    logic [fecr_pkg::DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(15))
      0:       v[7:0] = 8'hFF;
      1:       v[fecr_pkg::CELL_BITS-1 -: 8] = 8'hFF;
      2:       begin v[7:0] = 8'hFF; v[fecr_pkg::CELL_BITS-1 -: 8] = 8'hFF; end
      3:       v = '1;
      4:       v = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_RESTART, '1);
    send_item(fecr_pkg::CMD_WRITE,   '0);
    send_item(fecr_pkg::CMD_WRITE,   '1);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_WRITE,   64'hFF00_0000_0000_00FF);
    send_item(fecr_pkg::CMD_WRITE,   64'h00FF_FFFF_FFFF_FFFF);
    send_item(fecr_pkg::CMD_WRITE,   64'hFFFF_FFFF_FFFF_FF00);
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_WRITE,   64'h0123_4567_89AB_CDEF);
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_ERASE,   '0);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_WRITE,   64'h5555_5555_5555_5555);
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_WRITE,   64'hAAAA_AAAA_AAAA_AAAA);
    send_item(fecr_pkg::CMD_ERASE,   '1);
    send_item(fecr_pkg::CMD_WRITE,   '1);
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_READ,    '0);
    send_item(fecr_pkg::CMD_WRITE,   '0);
  endtask

  // fill the pool and run past its end, with and without a known position
  task automatic test_pool_wrap();
    send_item(fecr_pkg::CMD_ERASE, '0);
    for (int i = 0; i < fecr_pkg::CELL_COUNT; i++) begin
      send_item(fecr_pkg::CMD_WRITE, {$urandom, $urandom});
    end
    send_item(fecr_pkg::CMD_RESTART, '0);
    send_item(fecr_pkg::CMD_WRITE, {$urandom, $urandom});
    for (int i = 1; i < fecr_pkg::CELL_COUNT; i++) begin
      send_item(fecr_pkg::CMD_WRITE, {$urandom, $urandom});
    end
    send_item(fecr_pkg::CMD_READ, '0);
    send_item(fecr_pkg::CMD_WRITE, {$urandom, $urandom});
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    int             roll;
    fecr_pkg::cmd_t c;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 60) c = fecr_pkg::CMD_WRITE;
      else if (roll < 85) c = fecr_pkg::CMD_READ;
      else if (roll < 97) c = fecr_pkg::CMD_RESTART;
      else c = fecr_pkg::CMD_ERASE;
      send_item(c, random_image());
    end
  endtask

  // stall the output for a long stretch while items keep coming
  task automatic test_output_holdoff();
    fecr_pkg::cmd_t c;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(1) != 0) c = fecr_pkg::CMD_WRITE;
      else c = fecr_pkg::CMD_READ;
      send_item(c, random_image());
    end
  endtask

  initial begin
    wipe_pool();
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_left      = 0;
    idle_cycles    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_pool_wrap();
    test_random(350, 0, 0);
    test_random(350, 54, 0);
    test_random(350, 0, 54);
    test_output_holdoff();
    test_random(300, 21, 21);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d result items never arrived", expected_q.size());
      errors++;
    end

    $display("Covered %0d reads (%0d uninitialised), %0d writes (%0d pool wraps),",
             n_read, n_uninit, n_write, n_wrap);
    $display("%0d erases and %0d restarts; %0d result items checked.",
             n_erase, n_restart, n_results);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fecr_pkg.sv
hdl/fecr_ram.sv
hdl/fecr_useq.sv
hdl/fecr_datapath.sv
hdl/flash_eeprom_cell_rotation_unit.sv
bench/flash_eeprom_cell_rotation_unit_test.sv
